// ===== rtl/core/aupl_pkg.sv =====
// Package for the adder unit pool: lane count, operation codes, the group
// of completions passed from front to back, and the adder function.
// No dependencies.
package aupl_pkg;

  // unit_index is two bits wide, so at most four units can ever be reached
  localparam int unsigned Lanes    = 4;
  localparam int unsigned IdxW     = 2;
  localparam int unsigned TagW     = 4;
  localparam int unsigned DataW    = 32;
  localparam int unsigned LatW     = 4;
  localparam logic [LatW-1:0] LatReset = 4'd2;

  typedef enum logic [1:0] {
    MODE_ADD  = 2'd0,
    MODE_ADDI = 2'd1,
    MODE_SUB  = 2'd2,
    MODE_ZERO = 2'd3
  } mode_e;

  // completions of one tick, one lane per unit, in ascending unit order
  typedef struct packed {
    logic [Lanes-1:0]            mask;
    logic [Lanes-1:0][TagW-1:0]  tag;
    logic [Lanes-1:0][DataW-1:0] value;
  } grp_t;

  function automatic logic [DataW-1:0] compute(input logic [1:0] mode,
                                               input logic [DataW-1:0] a,
                                               input logic [DataW-1:0] b);
    logic [DataW-1:0] res;
    res = '0;
    unique case (mode) inside
      MODE_ADD, MODE_ADDI: res = a + b;
      MODE_SUB:            res = a - b;
      default:             res = '0;
    endcase
    return res;
  endfunction

endpackage

// ===== rtl/core/adder_unit_pool_with_latency.sv =====
// Pool of adder units with a configurable latency, Tomasulo style.
// Each accepted input item is one processor tick: it may issue one add,
// addi, sub or zero task to a unit, and every busy unit advances its
// counter; a unit that reaches the configured latency completes. The front
// takes one item per cycle and puts each tick's completions as one group
// into a queue of QUEUE_DEPTH groups; the back sends results one per cycle
// in ascending unit order, the last of a tick marked by last_o. The front
// stalls only while the queue is full and the back only while the output
// stalls, so the sustained rate is one item per cycle while ticks average at
// most one completion each; the single output register sets the drain rate.
// Depends on aupl_pkg, aupl_front, aupl_fifo and aupl_back.
module adder_unit_pool_with_latency #(
  parameter int unsigned NUM_UNITS   = 4,
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              issue_valid_i,
  input  logic [1:0]                        unit_index_i,
  input  logic [1:0]                        mode_i,
  input  logic [3:0]                        tag_i,
  input  logic signed [31:0]                operand_a_i,
  input  logic signed [31:0]                operand_b_i,
  input  logic                              cfg_we_i,
  input  logic [3:0]                        cfg_wdata_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [3:0]                        result_tag_o,
  output logic signed [31:0]                result_value_o,
  output logic                              last_o
);

  // units beyond the reach of unit_index never become busy
  localparam int unsigned NumLive =
    (NUM_UNITS < aupl_pkg::Lanes) ? NUM_UNITS : aupl_pkg::Lanes;

  logic           push, pop, empty, full;
  aupl_pkg::grp_t push_data, head;

  aupl_front #(
    .NUM_LIVE (NumLive)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .issue_valid_i (issue_valid_i),
    .unit_index_i  (unit_index_i),
    .mode_i        (mode_i),
    .tag_i         (tag_i),
    .operand_a_i   (operand_a_i),
    .operand_b_i   (operand_b_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .full_i        (full),
    .push_o        (push),
    .push_data_o   (push_data)
  );

  aupl_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .head_o      (head),
    .empty_o     (empty),
    .full_o      (full)
  );

  aupl_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_i         (head),
    .empty_i        (empty),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .result_tag_o   (result_tag_o),
    .result_value_o (result_value_o),
    .last_o         (last_o)
  );

endmodule

// ===== rtl/core/aupl_front.sv =====
// Front of the adder unit pool: accepts ticks, issues tasks to units,
// advances the unit counters and collects each tick's completions.
// Depends on aupl_pkg.
module aupl_front #(
  parameter int unsigned NUM_LIVE = 4
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            issue_valid_i,
  input  logic [aupl_pkg::IdxW-1:0]       unit_index_i,
  input  logic [1:0]                      mode_i,
  input  logic [aupl_pkg::TagW-1:0]       tag_i,
  input  logic signed [aupl_pkg::DataW-1:0] operand_a_i,
  input  logic signed [aupl_pkg::DataW-1:0] operand_b_i,
  input  logic                            cfg_we_i,
  input  logic [aupl_pkg::LatW-1:0]       cfg_wdata_i,
  input  logic                            full_i,
  output logic                            push_o,
  output aupl_pkg::grp_t                  push_data_o
);

  logic                        accept;
  logic [aupl_pkg::LatW-1:0]   lat_q;
  logic [NUM_LIVE-1:0]         busy_q, busy_d;
  logic [aupl_pkg::LatW-1:0]   cnt_q [NUM_LIVE];
  logic [aupl_pkg::LatW-1:0]   cnt_d [NUM_LIVE];
  logic [aupl_pkg::TagW-1:0]   tag_q [NUM_LIVE];
  logic [aupl_pkg::DataW-1:0]  val_q [NUM_LIVE];
  logic [NUM_LIVE-1:0]         hit;
  logic [aupl_pkg::DataW-1:0]  new_val;

  assign in_stall_o = full_i;
  assign accept     = in_valid_i & ~full_i;
  assign new_val    = aupl_pkg::compute(mode_i, operand_a_i, operand_b_i);

  always_comb begin
    logic                      busy_n;
    logic [aupl_pkg::LatW-1:0] cnt_inc;
    logic                      done;
    push_data_o = '0;
    for (int i = 0; i < NUM_LIVE; i++) begin
      hit[i]   = issue_valid_i && (unit_index_i == aupl_pkg::IdxW'(i));
      busy_n   = busy_q[i] | hit[i];
      cnt_inc  = cnt_q[i] + 1'b1;
      done     = busy_n && (cnt_inc == lat_q);
      busy_d[i] = busy_n & ~done;
      cnt_d[i]  = busy_n ? (done ? '0 : cnt_inc) : cnt_q[i];
      push_data_o.mask[i]  = done;
      push_data_o.tag[i]   = hit[i] ? tag_i : tag_q[i];
      push_data_o.value[i] = hit[i] ? new_val : val_q[i];
    end
  end

  assign push_o = accept & (|push_data_o.mask);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lat_q  <= aupl_pkg::LatReset;
      busy_q <= '0;
      for (int i = 0; i < NUM_LIVE; i++) cnt_q[i] <= '0;
    end else begin
      if (cfg_we_i) lat_q <= cfg_wdata_i;
      if (accept) begin
        busy_q <= busy_d;
        for (int i = 0; i < NUM_LIVE; i++) cnt_q[i] <= cnt_d[i];
      end
    end
  end

  // tag and result of a unit: overwrite on issue, counter untouched
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < NUM_LIVE; i++) begin
      if (accept && hit[i]) begin
        tag_q[i] <= tag_i;
        val_q[i] <= new_val;
      end
    end
  end

endmodule

// ===== rtl/core/aupl_fifo.sv =====
// Short queue of completion groups between front and back.
// Depends on aupl_pkg.
module aupl_fifo #(
  parameter int unsigned DEPTH = 4
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  aupl_pkg::grp_t push_data_i,
  input  logic           pop_i,
  output aupl_pkg::grp_t head_o,
  output logic           empty_o,
  output logic           full_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  aupl_pkg::grp_t mem_q [DEPTH];
  logic [AW-1:0]  wr_q, rd_q;
  logic [CW-1:0]  cnt_q;
  logic           do_push, do_pop;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == CW'(DEPTH));
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign head_o  = mem_q[rd_q];

  function automatic logic [AW-1:0] nxt(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= nxt(wr_q);
      if (do_pop)  rd_q <= nxt(rd_q);
      if (do_push && !do_pop)      cnt_q <= cnt_q + 1'b1;
      else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= push_data_i;
  end

endmodule

// ===== rtl/core/aupl_back.sv =====
// Back of the adder unit pool: takes completion groups from the queue and
// sends them out one result a cycle unless the output stalls, lowest unit
// first, marking the last. Depends on aupl_pkg.
module aupl_back (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  aupl_pkg::grp_t                    head_i,
  input  logic                              empty_i,
  output logic                              pop_o,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [aupl_pkg::TagW-1:0]         result_tag_o,
  output logic signed [aupl_pkg::DataW-1:0] result_value_o,
  output logic                              last_o
);

  aupl_pkg::grp_t                grp_q;
  logic [aupl_pkg::Lanes-1:0]    rem_q, rem_d;
  logic [aupl_pkg::Lanes-1:0]    pick;
  logic [aupl_pkg::IdxW-1:0]     sel;
  logic [aupl_pkg::Lanes-1:0]    rem_left;
  logic                          out_load;
  logic                          emit;
  logic                          load_grp;
  logic                          out_valid_q;
  logic [aupl_pkg::TagW-1:0]     tag_q;
  logic [aupl_pkg::DataW-1:0]    val_q;
  logic                          last_q;

  // lowest pending unit
  always_comb begin
    sel  = '0;
    pick = '0;
    for (int i = aupl_pkg::Lanes - 1; i >= 0; i--) begin
      if (rem_q[i]) begin
        sel  = aupl_pkg::IdxW'(i);
        pick = aupl_pkg::Lanes'(1) << i;
      end
    end
  end

  assign out_load = ~out_valid_q | ~out_stall_i;
  assign emit     = out_load & (|rem_q);
  assign rem_left = rem_q & ~pick;

  always_comb begin
    rem_d    = rem_q;
    load_grp = 1'b0;
    if (emit) rem_d = rem_left;
    // refill as soon as the current group is used up
    if (((rem_q == '0) || (emit && rem_left == '0)) && !empty_i) begin
      load_grp = 1'b1;
      rem_d    = head_i.mask;
    end
  end

  assign pop_o = load_grp;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      rem_q <= rem_d;
      if (out_load) out_valid_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_grp) grp_q <= head_i;
    if (emit) begin
      tag_q  <= grp_q.tag[sel];
      val_q  <= grp_q.value[sel];
      last_q <= (rem_left == '0);
    end
  end

  assign out_valid_o    = out_valid_q;
  assign result_tag_o   = tag_q;
  assign result_value_o = val_q;
  assign last_o         = last_q;

endmodule

// ===== tb/sv/adder_unit_pool_with_latency_chk.sv =====
// Checker for the adder unit pool: watches the item, result and latency write
// ports, predicts each tick's completions and compares them in order.
// Depends on aupl_pkg.
module adder_unit_pool_with_latency_chk #(
  parameter int unsigned NUM_UNITS = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic        issue_valid_i,
  input  logic [1:0]  unit_index_i,
  input  logic [1:0]  mode_i,
  input  logic [3:0]  tag_i,
  input  logic [31:0] operand_a_i,
  input  logic [31:0] operand_b_i,
  input  logic        cfg_we_i,
  input  logic [3:0]  cfg_wdata_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [3:0]  result_tag_i,
  input  logic [31:0] result_value_i,
  input  logic        last_i,
  output int          errors_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [aupl_pkg::TagW-1:0]  tag;
    logic [aupl_pkg::DataW-1:0] value;
    logic                       last;
  } sum_t;

  logic [aupl_pkg::LatW-1:0]  latency;
  logic                       lane_busy  [NUM_UNITS];
  logic [aupl_pkg::LatW-1:0]  lane_count [NUM_UNITS];
  logic [aupl_pkg::TagW-1:0]  lane_tag   [NUM_UNITS];
  logic [aupl_pkg::DataW-1:0] lane_sum   [NUM_UNITS];
  sum_t                       owed_results [$];
  int                         errors = 0;
  int                         owed_n = 0;

  assign errors_o  = errors;
  assign pending_o = owed_n;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("ERROR %0t: %s: got %h, want %h", $time, what, got, want);
    errors++;
  endtask

  // One tick of the pool: issue first, then every busy unit counts on.
  task automatic advance_pool(input logic issue,
                              input logic [aupl_pkg::IdxW-1:0] idx,
                              input aupl_pkg::mode_e op,
                              input logic [aupl_pkg::TagW-1:0] tg,
                              input logic [aupl_pkg::DataW-1:0] a,
                              input logic [aupl_pkg::DataW-1:0] b);
    sum_t done_q [$];
    sum_t rec;
    if (issue && idx < NUM_UNITS) begin
      lane_busy[idx] = 1'b1;
      lane_tag[idx]  = tg;
      case (op)
        aupl_pkg::MODE_ADD, aupl_pkg::MODE_ADDI: lane_sum[idx] = a + b;
        aupl_pkg::MODE_SUB:                      lane_sum[idx] = a - b;
        default:                                 lane_sum[idx] = '0;
      endcase
    end
    for (int u = 0; u < NUM_UNITS; u++) begin
      if (lane_busy[u]) begin
        // the counter wraps at four bits, so a latency of zero takes 16 ticks
        lane_count[u] = lane_count[u] + 1'b1;
        if (lane_count[u] == latency) begin
          lane_count[u] = '0;
          lane_busy[u]  = 1'b0;
          rec.tag   = lane_tag[u];
          rec.value = lane_sum[u];
          rec.last  = 1'b0;
          done_q.push_back(rec);
        end
      end
    end
    if (done_q.size() > 0) done_q[done_q.size()-1].last = 1'b1;
    foreach (done_q[k]) owed_results.push_back(done_q[k]);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    sum_t want;
    if (!rst_ni) begin
      latency = aupl_pkg::LatReset;
      for (int u = 0; u < NUM_UNITS; u++) begin
        lane_busy[u]  = 1'b0;
        lane_count[u] = '0;
      end
      owed_results.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (owed_results.size() == 0) begin
          report_mismatch("result with nothing owed", result_value_i, '0);
        end else begin
          want = owed_results.pop_front();
          if (result_tag_i !== want.tag)
            report_mismatch("result_tag", 32'(result_tag_i), 32'(want.tag));
          if (result_value_i !== want.value)
            report_mismatch("result_value", result_value_i, want.value);
          if (last_i !== want.last)
            report_mismatch("last", 32'(last_i), 32'(want.last));
        end
      end
      if (in_valid_i && !in_stall_i)
        advance_pool(issue_valid_i, unit_index_i, aupl_pkg::mode_e'(mode_i), tag_i,
                     operand_a_i, operand_b_i);
      if (cfg_we_i) latency = cfg_wdata_i;
    end
    owed_n = owed_results.size();
  end

endmodule

// ===== tb/sv/adder_unit_pool_with_latency_tb.sv =====
// Top of the adder unit pool testbench: clock, reset, directed and random
// ticks, latency writes, output back-pressure and the verdict.
// Depends on aupl_pkg, adder_unit_pool_with_latency and its checker.
module adder_unit_pool_with_latency_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QuietLimit = 3000;

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            in_valid = 1'b0;
  logic            in_stall;
  logic            issue_valid = 1'b0;
  logic [1:0]      unit_index = '0;
  aupl_pkg::mode_e op_mode = aupl_pkg::MODE_ADD;
  logic [3:0]      tag = '0;
  logic [31:0]     operand_a = '0;
  logic [31:0]     operand_b = '0;
  logic            cfg_we = 1'b0;
  logic [3:0]      cfg_wdata = '0;
  logic            out_valid;
  logic            out_stall = 1'b0;
  logic [3:0]      result_tag;
  logic [31:0]     result_value;
  logic            last;
  int              errors;
  int              pending;
  bit              hold_req = 1'b0;
  int              quiet_cycles = 0;

  adder_unit_pool_with_latency dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .issue_valid_i  (issue_valid),
    .unit_index_i   (unit_index),
    .mode_i         (op_mode),
    .tag_i          (tag),
    .operand_a_i    (operand_a),
    .operand_b_i    (operand_b),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .result_tag_o   (result_tag),
    .result_value_o (result_value),
    .last_o         (last)
  );

  adder_unit_pool_with_latency_chk chk (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .issue_valid_i  (issue_valid),
    .unit_index_i   (unit_index),
    .mode_i         (op_mode),
    .tag_i          (tag),
    .operand_a_i    (operand_a),
    .operand_b_i    (operand_b),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .result_tag_i   (result_tag),
    .result_value_i (result_value),
    .last_i         (last),
    .errors_o       (errors),
    .pending_o      (pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 7))
      0:       return 32'h0000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h8000_0000;
      3:       return 32'hFFFF_FFFF;
      4:       return 32'h0000_0001;
      default: return $urandom();
    endcase
  endfunction

  // Offer one tick, hold it until taken, then maybe leave a gap.
  task automatic send_tick(input logic issue, input logic [1:0] idx,
                           input aupl_pkg::mode_e op, input logic [3:0] tg,
                           input logic [31:0] a, input logic [31:0] b);
    int r;
    int gap;
    in_valid    <= 1'b1;
    issue_valid <= issue;
    unit_index  <= idx;
    op_mode     <= op;
    tag         <= tg;
    operand_a   <= a;
    operand_b   <= b;
    do @(posedge clk); while (in_stall);
    r = $urandom_range(0, 19);
    if (r < 12)      gap = 0;
    else if (r < 19) gap = $urandom_range(1, 3);
    else             gap = $urandom_range(8, 30);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic quiet_tick();
    send_tick(1'b0, 2'($urandom_range(0, 3)), aupl_pkg::mode_e'($urandom_range(0, 3)),
              4'($urandom_range(0, 15)), pick_operand(), pick_operand());
  endtask

  task automatic random_ticks(input int n);
    for (int k = 0; k < n; k++)
      send_tick($urandom_range(0, 3) != 0, 2'($urandom_range(0, 3)),
                aupl_pkg::mode_e'($urandom_range(0, 3)), 4'($urandom_range(0, 15)),
                pick_operand(), pick_operand());
  endtask

  // Drain owed results, let the pipeline settle, then write the latency.
  task automatic set_latency(input logic [3:0] val);
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (8) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    logic [3:0] lat;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset latency of two: operand extremes, every operation
    send_tick(1'b1, 2'd0, aupl_pkg::MODE_ADD,  4'h0, 32'h7FFF_FFFF, 32'h0000_0001);
    send_tick(1'b1, 2'd1, aupl_pkg::MODE_ADDI, 4'hF, 32'h8000_0000, 32'hFFFF_FFFF);
    send_tick(1'b1, 2'd2, aupl_pkg::MODE_SUB,  4'h5, 32'h8000_0000, 32'h0000_0001);
    send_tick(1'b1, 2'd3, aupl_pkg::MODE_SUB,  4'hA, 32'h0000_0000, 32'h8000_0000);
    send_tick(1'b1, 2'd0, aupl_pkg::MODE_ZERO, 4'h3, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // overwrite a busy unit: second task wins, counter runs on
    send_tick(1'b1, 2'd1, aupl_pkg::MODE_ADD,  4'h6, 32'h1234_5678, 32'h0000_0000);
    send_tick(1'b1, 2'd1, aupl_pkg::MODE_SUB,  4'h9, 32'h0000_0000, 32'h0000_0001);
    quiet_tick();

    // latency zero, then lowered under the running counter: unit 0 wraps
    // round and completes on the same tick as a fresh issue to unit 1
    set_latency(4'd0);
    send_tick(1'b1, 2'd0, aupl_pkg::MODE_ADD, 4'h1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    repeat (4) quiet_tick();
    set_latency(4'd1);
    repeat (11) quiet_tick();
    send_tick(1'b1, 2'd1, aupl_pkg::MODE_ADDI, 4'h2, 32'h0000_0010, 32'hFFFF_FFF0);

    for (int p = 0; p < 7; p++) begin
      case (p)
        0:       lat = 4'd15;
        1:       lat = 4'd0;
        2:       lat = 4'd1;
        3:       lat = 4'd2;
        6:       lat = 4'd1;
        default: lat = 4'($urandom_range(3, 14));
      endcase
      set_latency(lat);
      // one result per issue here, so a long hold fills the queue quickly
      if (p == 2) hold_req = 1'b1;
      random_ticks(29);
    end

    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (20) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Output back-pressure: alternate free runs and holds of random length.
  initial begin
    int len;
    bit held;
    held = 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      len = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 6);
      out_stall <= 1'b0;
      // cut the free run short once the long hold is wanted
      for (int k = 0; k < len && !(hold_req && !held); k++) @(posedge clk);
      if (hold_req && !held) begin
        held = 1'b1;
        len  = 300;
      end else begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
      end
      out_stall <= 1'b1;
      repeat (len) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

// ===== files.f =====
rtl/core/aupl_pkg.sv
rtl/core/aupl_front.sv
rtl/core/aupl_fifo.sv
rtl/core/aupl_back.sv
rtl/core/adder_unit_pool_with_latency.sv
tb/sv/adder_unit_pool_with_latency_chk.sv
tb/sv/adder_unit_pool_with_latency_tb.sv
